// File: rtl/core/mssm_pkg.sv
`default_nettype none

package mssm_pkg;

   localparam int OPCODE_W = 1;
   localparam int SEL_W    = 3;
   localparam int SIZE_W   = 7;
   localparam int USE_W    = 4;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [OPCODE_W-1:0] OP_PUSH = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_LEN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STACKS_IN_USE = 2'd1;

   localparam logic [SIZE_W-1:0] REGION_LEN_RESET    = 7'd64;
   localparam logic [USE_W-1:0]  STACKS_IN_USE_RESET = 4'd8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                pop_ok;
   } mssm_dec_type;

endpackage

`default_nettype wire

// File: rtl/core/mssm_ram.sv
`default_nettype none

module mssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/mssm_ctrl.sv
`default_nettype none

module mssm_ctrl #(
   parameter int NUM_STACKS  = 8,
   parameter int STACK_DEPTH = 64,
   parameter int AW = ((NUM_STACKS * STACK_DEPTH) > 1) ? $clog2(NUM_STACKS * STACK_DEPTH) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [mssm_pkg::OPCODE_W-1:0]  opcode,
   input  wire logic [mssm_pkg::SEL_W-1:0]     stack_select,
   input  wire logic [mssm_pkg::SIZE_W-1:0]    region_len,
   input  wire logic [mssm_pkg::USE_W-1:0]     stacks_in_use,
   output mssm_pkg::mssm_dec_type              dec,
   output logic                                mem_wr_en,
   output logic                                mem_rd_en,
   output logic [AW-1:0]                       mem_addr
);

   import mssm_pkg::*;

   localparam int CW    = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W = (CW > SIZE_W) ? CW : SIZE_W;
   localparam int IW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int EW    = 7;

   logic [CW-1:0]    count_ff [NUM_STACKS];
   logic [CW-1:0]    count_in;
   logic             count_we;
   logic [IW-1:0]    idx;
   logic [CW-1:0]    n;
   logic [EW-1:0]    enabled;
   logic [CMP_W-1:0] cap;
   logic [CW-1:0]    slot;

   assign idx = IW'(stack_select);
   assign n   = count_ff[idx];

   always_comb begin
      enabled = (EW'(stacks_in_use) > EW'(NUM_STACKS)) ? EW'(NUM_STACKS) : EW'(stacks_in_use);
      cap     = (CMP_W'(region_len) > CMP_W'(STACK_DEPTH)) ? CMP_W'(STACK_DEPTH)
                                                           : CMP_W'(region_len);
      dec.status = ST_OK;
      dec.pop_ok = 1'b0;
      count_we   = 1'b0;
      count_in   = n;
      slot       = n;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      if (EW'(stack_select) >= enabled) begin
         dec.status = ST_INVALID;
      end else if (opcode == OP_PUSH) begin
         if (CMP_W'(n) >= cap) begin
            dec.status = ST_FULL;
         end else begin
            count_we  = accept;
            count_in  = n + CW'(1);
            mem_wr_en = accept;
         end
      end else begin
         if (n == '0) begin
            dec.status = ST_EMPTY;
         end else begin
            dec.pop_ok = 1'b1;
            count_we   = accept;
            count_in   = n - CW'(1);
            slot       = n - CW'(1);
            mem_rd_en  = accept;
         end
      end
      mem_addr = AW'(AW'(stack_select) * AW'(STACK_DEPTH)) + AW'(slot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (count_we) begin
         count_ff[idx] <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/multi_stack_shared_memory.sv
`default_nettype none

// Several LIFO stacks in one shared word memory; stack s owns words
// s*STACK_DEPTH on; the first min(region length, STACK_DEPTH) are usable.
// req channel: one push or pop item on a selected stack (valid/ready).
// rsp channel: one item per request, popped word (all ones for a push or
// a refused request) and a status: ok, full, empty or invalid stack.
// csr channel: index 0 region length, index 1 stacks_in_use; other indexes
// are ignored. Always ready; write only while the block is idle.
// Path: the edge that accepts a request makes the decision and memory
// access and loads the pending stage; the registered read data and status
// then enter the response register when the pending stage moves on.
// Throughput: one item per cycle while responses are taken; the fill counts
// sit in flops, the words in one memory touched at one address per item.
// Reset: all stacks empty, region length 64, stacks_in_use 8. Memory is not
// cleared; only pushed words are ever read back.
// Stall: a held response keeps one more decided item in a pending stage;
// req_ready drops when both are full and rises as soon as rsp_ready does.

module multi_stack_shared_memory #(
   parameter int NUM_STACKS  = 8,
   parameter int STACK_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [mssm_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire logic [mssm_pkg::SEL_W-1:0]            req_stack_select,
   input  wire logic signed [DATA_WIDTH-1:0]          req_push_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [DATA_WIDTH-1:0]               rsp_pop_value,
   output logic [mssm_pkg::STATUS_W-1:0]              rsp_status,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mssm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [mssm_pkg::CSR_DATA_W-1:0]       csr_data
);

   import mssm_pkg::*;

   localparam int DEPTH = NUM_STACKS * STACK_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [SIZE_W-1:0]     region_len_ff;
   logic [USE_W-1:0]      stacks_in_use_ff;
   logic                  accept;
   mssm_dec_type          dec;
   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   logic                  pend_valid_ff;
   logic                  pend_valid_in;
   logic [STATUS_W-1:0]   pend_status_ff;
   logic                  pend_pop_ok_ff;
   logic                  pend_move;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_pop_value_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_len_ff    <= REGION_LEN_RESET;
         stacks_in_use_ff <= STACKS_IN_USE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REGION_LEN: begin
               region_len_ff <= csr_data;
            end
            CSR_STACKS_IN_USE: begin
               stacks_in_use_ff <= USE_W'(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   assign pend_move = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_valid_ff || pend_move;
   assign accept    = req_valid && req_ready;

   mssm_ctrl #(
      .NUM_STACKS  (NUM_STACKS),
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .opcode        (req_opcode),
      .stack_select  (req_stack_select),
      .region_len    (region_len_ff),
      .stacks_in_use (stacks_in_use_ff),
      .dec           (dec),
      .mem_wr_en     (mem_wr_en),
      .mem_rd_en     (mem_rd_en),
      .mem_addr      (mem_addr)
   );

   mssm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (req_push_value),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
      end else if (pend_move) begin
         pend_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (pend_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= dec.status;
         pend_pop_ok_ff <= dec.pop_ok;
      end
      if (pend_move) begin
         rsp_status_ff    <= pend_status_ff;
         rsp_pop_value_ff <= pend_pop_ok_ff ? mem_rd_data : '1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_pop_value = rsp_pop_value_ff;

endmodule

`default_nettype wire
